// ===== src/lab_pkg.sv =====
// Shared types, constants and arctangent table for the light array bearing estimator.
package lab_pkg;

  // Default parameter values
  localparam int SENSOR_COUNT_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;

  // Datapath widths fixed by the field formats
  localparam int XY_W    = 44;   // CORDIC x/y, holds a negated and grown 40-bit sum
  localparam int ACC_W   = 40;   // x/y accumulators
  localparam int SUM_W   = 20;   // weight and light sums
  localparam int MUL_W   = 18;   // multiplier operand width
  localparam int PROD_W  = 2 * MUL_W;
  localparam int IDX_W   = 4;
  localparam int INT_W   = 16;
  localparam int BRG_W   = 16;
  localparam int SF_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 96;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_DEPTH = 24;

  // Ring weight start value, 0.60725 in Q.14
  localparam logic signed [XY_W-1:0] GAIN_INIT = XY_W'(9949);

  // Register reset values
  localparam logic [INT_W-1:0] SENSOR_THR_RST = 16'd102;
  localparam logic [SUM_W-1:0] LIGHT_THR_RST  = 20'd1024;
  localparam logic [SF_W-1:0]  SMOOTH_RST     = 9'd77;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH     = 2'd2;

  // arctan(2^-i) in 2^32 per turn
  localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ACC_Y,
    ST_CHECK,
    ST_VEC,
    ST_ROUND,
    ST_SMOOTH,
    ST_UPDATE,
    ST_OUT
  } lab_state_t;

  // Control of the shared CORDIC unit
  typedef struct packed {
    logic load;
    logic run;
    logic vectoring;
  } lab_cordic_ctrl_t;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_SEL_X,
    MUL_SEL_Y,
    MUL_SEL_SMOOTH
  } lab_mul_sel_t;

  // Arctangent step at a given angle resolution, rounded half up
  function automatic logic [31:0] atan_step(input logic [ATAN_IDX_W-1:0] idx,
                                            input int unsigned bits);
    logic [32:0] t;
    int unsigned sh;
    sh = 32 - bits;
    if (idx < ATAN_IDX_W'(ATAN_DEPTH)) begin
      t = {1'b0, ATAN_TAB[idx]} + (33'd1 << (sh - 1));
    end else begin
      t = '0;
    end
    return 32'(t >> sh);
  endfunction

endpackage

// ===== src/light_array_bearing_estimator.sv =====
// Light array bearing estimator: sample accumulation, CORDIC bearing, smoothing and output.
// A sample at or below threshold only adds to the light sum; one above it also runs the
// rotation CORDIC for the ring weight and two passes of the shared multiplier. A last
// sample then adds check, vectoring CORDIC, rounding, smoothing multiply, update and output
// load (no vectoring or rounding for an invalid or zero-vector frame) and any output stall.
// Synchronous active-high reset restores register defaults, clears the sums and sequencer state.
module light_array_bearing_estimator #(
  parameter int SENSOR_COUNT = lab_pkg::SENSOR_COUNT_DEF,
  parameter int ANGLE_BITS   = lab_pkg::ANGLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sensor_index[3:0], intensity[19:4], heading[35:20], zero pad
  input  logic [lab_pkg::IN_DATA_W-1:0]         s_tdata,
  input  logic                                  s_tlast,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // valid[0], raw_bearing[16:1], smoothed_bearing[32:17], world_bearing[48:33],
  // weight_total[68:49], light_total[88:69], light_ok[89], zero pad
  output logic [lab_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lab_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lab_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import lab_pkg::*;

  localparam int ZW     = ANGLE_BITS + 2;
  localparam int SH_DN  = (ANGLE_BITS > BRG_W) ? ANGLE_BITS - BRG_W : 0;
  localparam int SH_UP  = (ANGLE_BITS < BRG_W) ? BRG_W - ANGLE_BITS : 0;
  localparam int RND_W  = 41;
  localparam logic [RND_W-1:0] RND = (RND_W'(1) << SH_DN) >> 1;
  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(2 ** (ANGLE_BITS - 2));
  localparam logic signed [ZW-1:0] Z_HALF    = ZW'(2 ** (ANGLE_BITS - 1));

  // Configuration registers
  logic [INT_W-1:0] sensor_threshold;
  logic [SUM_W-1:0] total_light_threshold;
  logic [SF_W-1:0]  smooth_factor;

  // Sequencer and frame state
  lab_state_t state, state_next;
  logic signed [ACC_W-1:0] x_acc, y_acc;
  logic [SUM_W-1:0] w_acc, l_acc;
  logic [BRG_W-1:0] smoothed, raw;
  logic primed, valid;
  logic [INT_W-1:0] inten_q;
  logic [BRG_W-1:0] heading_q;
  logic last_q;

  // Input fields
  logic [IDX_W-1:0] s_idx;
  logic [INT_W-1:0] s_inten;
  logic [BRG_W-1:0] s_heading;
  assign s_idx     = s_tdata[3:0];
  assign s_inten   = s_tdata[19:4];
  assign s_heading = s_tdata[35:20];

  logic accept, above, out_free;
  assign accept    = s_tvalid && s_tready;
  assign above     = s_inten > sensor_threshold;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Shared units
  lab_cordic_ctrl_t cctrl;
  logic signed [XY_W-1:0] c_x_in, c_y_in, c_x, c_y;
  logic signed [ZW-1:0]   c_z_in, c_z;
  logic                   c_done;
  lab_mul_sel_t           mul_sel;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  lab_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk   (clk),
    .ctrl  (cctrl),
    .x_in  (c_x_in),
    .y_in  (c_y_in),
    .z_in  (c_z_in),
    .x_out (c_x),
    .y_out (c_y),
    .z_out (c_z),
    .done  (c_done)
  );

  lab_mult u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Ring angle of the incoming sample from a constant table, folded into [-quarter, quarter]
  logic [ANGLE_BITS-1:0]       angle_a;
  logic signed [ZW-1:0]        z_a, rot_z;
  logic signed [XY_W-1:0]      rot_x;
  always_comb begin
    angle_a = '0;
    for (int i = 0; i < 2 ** IDX_W; i++) begin
      if (s_idx == IDX_W'(i)) begin
        angle_a = ANGLE_BITS'((longint'(i) << ANGLE_BITS) / SENSOR_COUNT);
      end
    end
    z_a       = ZW'(signed'(angle_a));
    rot_x     = GAIN_INIT;
    rot_z     = z_a;
    if (z_a > Z_QUARTER) begin
      rot_z = z_a - Z_HALF;
      rot_x = -GAIN_INIT;
    end else if (z_a < -Z_QUARTER) begin
      rot_z = z_a + Z_HALF;
      rot_x = -GAIN_INIT;
    end
  end

  // Vectoring start: move x into the right half plane
  logic signed [XY_W-1:0] vx, vy, vec_x, vec_y;
  logic signed [ZW-1:0]   vec_z;
  logic                   zero_vec, valid_now;
  always_comb begin
    vx = XY_W'(x_acc);
    vy = XY_W'(y_acc);
    if (vx < 0) begin
      vec_x = -vx;
      vec_y = -vy;
      vec_z = Z_HALF;
    end else begin
      vec_x = vx;
      vec_y = vy;
      vec_z = '0;
    end
    zero_vec  = (x_acc == '0) && (y_acc == '0);
    valid_now = w_acc > SUM_W'(sensor_threshold);
  end

  assign c_x_in = (state == ST_IDLE) ? rot_x : vec_x;
  assign c_y_in = (state == ST_IDLE) ? '0 : vec_y;
  assign c_z_in = (state == ST_IDLE) ? rot_z : vec_z;

  // Wrapped bearing difference in (-half, half]
  logic [BRG_W-1:0]      diff_u;
  logic signed [BRG_W:0] diff;
  always_comb begin
    diff_u = raw - smoothed;
    diff   = (diff_u > 16'd32768) ? {1'b1, diff_u} : {1'b0, diff_u};
  end

  // Multiplier operands
  always_comb begin
    case (mul_sel)
      MUL_SEL_X: begin
        mul_a = MUL_W'({2'b00, inten_q});
        mul_b = MUL_W'(c_x);
      end
      MUL_SEL_Y: begin
        mul_a = MUL_W'({2'b00, inten_q});
        mul_b = MUL_W'(c_y);
      end
      MUL_SEL_SMOOTH: begin
        mul_a = MUL_W'({{(MUL_W - SF_W){1'b0}}, smooth_factor});
        mul_b = MUL_W'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Saturating accumulate of a product
  logic signed [ACC_W:0]   sum_x, sum_y;
  logic signed [ACC_W-1:0] sat_x, sat_y;
  logic [SUM_W:0]          sum_w, sum_l;
  always_comb begin
    sum_x = (ACC_W + 1)'(x_acc) + (ACC_W + 1)'(prod);
    sum_y = (ACC_W + 1)'(y_acc) + (ACC_W + 1)'(prod);
    sat_x = (sum_x[ACC_W] != sum_x[ACC_W-1]) ?
            {sum_x[ACC_W], {(ACC_W - 1){~sum_x[ACC_W]}}} : sum_x[ACC_W-1:0];
    sat_y = (sum_y[ACC_W] != sum_y[ACC_W-1]) ?
            {sum_y[ACC_W], {(ACC_W - 1){~sum_y[ACC_W]}}} : sum_y[ACC_W-1:0];
    sum_w = {1'b0, w_acc} + (SUM_W + 1)'(inten_q);
    sum_l = {1'b0, l_acc} + (SUM_W + 1)'(s_inten);
  end

  // Round the CORDIC angle to 16 bits
  logic [RND_W-1:0] ang_ext, ang_rnd;
  logic [BRG_W-1:0] raw_round;
  always_comb begin
    ang_ext   = RND_W'(c_z[ANGLE_BITS-1:0]);
    ang_rnd   = (ang_ext + RND) >> SH_DN;
    raw_round = BRG_W'(ang_rnd << SH_UP);
  end

  // Smoothing step, low 16 bits of floor((sf * diff + 128) / 256)
  logic signed [PROD_W-1:0] step_full;
  logic [BRG_W-1:0]         step;
  always_comb begin
    step_full = prod + PROD_W'(128);
    step      = step_full[BRG_W+7:8];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (above) state_next = ST_ROT;
          else if (s_tlast) state_next = ST_CHECK;
        end
      end
      ST_ROT:    if (c_done) state_next = ST_MUL_X;
      ST_MUL_X:  state_next = ST_MUL_Y;
      ST_MUL_Y:  state_next = ST_ACC_Y;
      ST_ACC_Y:  state_next = last_q ? ST_CHECK : ST_IDLE;
      ST_CHECK:  state_next = (valid_now && !zero_vec) ? ST_VEC : ST_SMOOTH;
      ST_VEC:    if (c_done) state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_SMOOTH;
      ST_SMOOTH: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    s_tready        = 1'b0;
    cctrl.load      = 1'b0;
    cctrl.run       = 1'b0;
    cctrl.vectoring = 1'b0;
    mul_sel         = MUL_SEL_X;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cctrl.load = accept && above;
      end
      ST_ROT:    cctrl.run = 1'b1;
      ST_MUL_X:  mul_sel = MUL_SEL_X;
      ST_MUL_Y:  mul_sel = MUL_SEL_Y;
      ST_CHECK:  cctrl.load = valid_now && !zero_vec;
      ST_VEC: begin
        cctrl.run       = 1'b1;
        cctrl.vectoring = 1'b1;
      end
      ST_SMOOTH: mul_sel = MUL_SEL_SMOOTH;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // State register, configuration and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state                 <= ST_IDLE;
      sensor_threshold      <= SENSOR_THR_RST;
      total_light_threshold <= LIGHT_THR_RST;
      smooth_factor         <= SMOOTH_RST;
      x_acc                 <= '0;
      y_acc                 <= '0;
      w_acc                 <= '0;
      l_acc                 <= '0;
      smoothed              <= '0;
      primed                <= 1'b0;
      m_tvalid              <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SENSOR_THR: sensor_threshold      <= cfg_data[INT_W-1:0];
          CFG_LIGHT_THR:  total_light_threshold <= cfg_data[SUM_W-1:0];
          CFG_SMOOTH:     smooth_factor         <= cfg_data[SF_W-1:0];
          default:        ;
        endcase
      end

      // result valid: set on load, cleared once taken
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) l_acc <= sum_l[SUM_W] ? {SUM_W{1'b1}} : sum_l[SUM_W-1:0];
        end
        ST_MUL_Y: x_acc <= sat_x;
        ST_ACC_Y: begin
          y_acc <= sat_y;
          w_acc <= sum_w[SUM_W] ? {SUM_W{1'b1}} : sum_w[SUM_W-1:0];
        end
        ST_UPDATE: begin
          if (!primed) begin
            smoothed <= raw;
            primed   <= 1'b1;
          end else if (valid) begin
            smoothed <= smoothed + step;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            x_acc    <= '0;
            y_acc    <= '0;
            w_acc    <= '0;
            l_acc    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Item and result payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      inten_q   <= s_inten;
      heading_q <= s_heading;
      last_q    <= s_tlast;
    end
    if (state == ST_CHECK) begin
      valid <= valid_now;
      raw   <= '0;
    end
    if (state == ST_ROUND) raw <= raw_round;
    if (state == ST_OUT && out_free) begin
      m_tdata <= {6'b0,
                  valid && (l_acc > total_light_threshold),
                  l_acc,
                  w_acc,
                  heading_q + smoothed,
                  smoothed,
                  raw,
                  valid};
    end
  end

endmodule

// ===== src/lab_cordic.sv =====
// Shared iterative CORDIC: one shift-add micro-rotation per run cycle, rotation or vectoring.
module lab_cordic #(
  parameter int ANGLE_BITS = lab_pkg::ANGLE_BITS_DEF
) (
  input  logic                                     clk,
  input  lab_pkg::lab_cordic_ctrl_t                ctrl,
  input  logic signed [lab_pkg::XY_W-1:0]          x_in,
  input  logic signed [lab_pkg::XY_W-1:0]          y_in,
  input  logic signed [ANGLE_BITS+1:0]             z_in,
  output logic signed [lab_pkg::XY_W-1:0]          x_out,
  output logic signed [lab_pkg::XY_W-1:0]          y_out,
  output logic signed [ANGLE_BITS+1:0]             z_out,
  output logic                                     done
);
  import lab_pkg::*;

  localparam int ZW  = ANGLE_BITS + 2;
  localparam int ITW = $clog2(ANGLE_BITS);

  logic signed [XY_W-1:0] x, y, xs, ys;
  logic signed [ZW-1:0]   z, at;
  logic [ITW-1:0]         iter;
  logic                   neg;

  // Shifted terms and direction of this micro-rotation
  always_comb begin
    xs  = x >>> iter;
    ys  = y >>> iter;
    at  = ZW'(atan_step(ATAN_IDX_W'(iter), ANGLE_BITS));
    neg = ctrl.vectoring ? ~y[XY_W-1] : z[ZW-1];
  end

  assign done  = ctrl.run && (iter == ITW'(ANGLE_BITS - 1));
  assign x_out = x;
  assign y_out = y;
  assign z_out = z;

  // Iteration registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x    <= x_in;
      y    <= y_in;
      z    <= z_in;
      iter <= '0;
    end else if (ctrl.run) begin
      if (neg) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
      iter <= iter + 1'b1;
    end
  end

endmodule

// ===== src/lab_mult.sv =====
// Shared signed multiplier with registered product.
module lab_mult (
  input  logic                                 clk,
  input  logic signed [lab_pkg::MUL_W-1:0]     a,
  input  logic signed [lab_pkg::MUL_W-1:0]     b,
  output logic signed [lab_pkg::PROD_W-1:0]    p
);
  import lab_pkg::*;

  // One product per cycle
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
